FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

FILE: design/wpps_pkg.sv
// ----------------------------------------------------------------------------
// wpps_pkg
// Types, constants and register map of the window paced packet sender.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wpps_pkg;

  localparam int unsigned CfgWinW      = 6;
  localparam int unsigned IdW          = 32;
  localparam int unsigned AddrW        = 48;
  localparam int unsigned TimeW        = 63;
  localparam int unsigned SeqW         = 31;
  localparam int unsigned IntervalW    = 32;
  localparam int unsigned DeadlineW    = 64;
  localparam int unsigned MaxWindowDef = 63;
  localparam int unsigned ShrinkStep   = 20;

  localparam int unsigned ApbAddrW  = 6;
  localparam int unsigned ApbDataW  = 64;
  localparam int unsigned RegIdxLsb = 3;
  localparam int unsigned RegIdxW   = 3;

  localparam logic [CfgWinW-1:0]   TargetWindowRst  = 6'd63;
  localparam logic [CfgWinW-1:0]   InitialWindowRst = 6'd10;
  localparam logic [IntervalW-1:0] SendIntervalRst  = 32'd1000000;
  localparam logic signed [IdW-1:0] MinusOne        = '1;

  typedef enum logic [RegIdxW-1:0] {
    RegTarget   = 3'd0,
    RegInitial  = 3'd1,
    RegOwnId    = 3'd2,
    RegInterval = 3'd3,
    RegServer   = 3'd4,
    RegPreset   = 3'd5
  } reg_idx_e;

  typedef enum logic [0:0] {
    OpRx   = 1'b0,
    OpTick = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StIdle,
    StEval,
    StEmit
  } state_e;

  typedef struct packed {
    op_e                     op;
    logic signed [IdW-1:0]   rx_sequence;
    logic signed [IdW-1:0]   rx_ack;
    logic signed [IdW-1:0]   rx_sender;
    logic [AddrW-1:0]        rx_source;
    logic [TimeW-1:0]        now_ns;
  } in_t;

  typedef struct packed {
    logic [SeqW-1:0]  tx_sequence;
    logic [AddrW-1:0] tx_dest;
    logic [TimeW-1:0] tx_time;
    logic             tx_last;
  } out_t;

  typedef struct packed {
    logic [CfgWinW-1:0]     target_window;
    logic [CfgWinW-1:0]     initial_window;
    logic signed [IdW-1:0]  own_id;
    logic [IntervalW-1:0]   send_interval;
    logic                   server_mode;
    logic [AddrW-1:0]       preset_peer;
  } cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic eval;
    logic step;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic emit_any;
    logic last;
  } sts_t;

endpackage

`default_nettype wire

FILE: design/wpps_regs.sv
// ----------------------------------------------------------------------------
// wpps_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wpps_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [wpps_pkg::ApbAddrW-1:0]      paddr,
  input  wire logic [wpps_pkg::ApbDataW-1:0]      pwdata,
  output logic [wpps_pkg::ApbDataW-1:0]           prdata,
  output logic                                    pready,
  output wpps_pkg::cfg_t                          cfg_o
);

  wpps_pkg::cfg_t     cfg_q, cfg_d;
  wpps_pkg::reg_idx_e idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = wpps_pkg::reg_idx_e'(paddr[wpps_pkg::RegIdxLsb +: wpps_pkg::RegIdxW]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        wpps_pkg::RegTarget:   cfg_d.target_window  = pwdata[wpps_pkg::CfgWinW-1:0];
        wpps_pkg::RegInitial:  cfg_d.initial_window = pwdata[wpps_pkg::CfgWinW-1:0];
        wpps_pkg::RegOwnId:    cfg_d.own_id         = $signed(pwdata[wpps_pkg::IdW-1:0]);
        wpps_pkg::RegInterval: cfg_d.send_interval  = pwdata[wpps_pkg::IntervalW-1:0];
        wpps_pkg::RegServer:   cfg_d.server_mode    = pwdata[0];
        wpps_pkg::RegPreset:   cfg_d.preset_peer    = pwdata[wpps_pkg::AddrW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_window  <= wpps_pkg::TargetWindowRst;
      cfg_q.initial_window <= wpps_pkg::InitialWindowRst;
      cfg_q.own_id         <= '0;
      cfg_q.send_interval  <= wpps_pkg::SendIntervalRst;
      cfg_q.server_mode    <= 1'b0;
      cfg_q.preset_peer    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      wpps_pkg::RegTarget:   prdata = wpps_pkg::ApbDataW'(cfg_q.target_window);
      wpps_pkg::RegInitial:  prdata = wpps_pkg::ApbDataW'(cfg_q.initial_window);
      wpps_pkg::RegOwnId:    prdata = wpps_pkg::ApbDataW'($unsigned(cfg_q.own_id));
      wpps_pkg::RegInterval: prdata = wpps_pkg::ApbDataW'(cfg_q.send_interval);
      wpps_pkg::RegServer:   prdata = wpps_pkg::ApbDataW'(cfg_q.server_mode);
      wpps_pkg::RegPreset:   prdata = wpps_pkg::ApbDataW'(cfg_q.preset_peer);
      default:               prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: design/wpps_ctrl.sv
// ----------------------------------------------------------------------------
// wpps_ctrl
// Sequencer: takes an item, lets the datapath evaluate it, then walks any burst.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wpps_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  input  wpps_pkg::sts_t      sts_i,
  output wpps_pkg::cmd_t      cmd_o
);

  wpps_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wpps_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      wpps_pkg::StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = wpps_pkg::StEval;
        end
      end
      wpps_pkg::StEval: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.emit_any ? wpps_pkg::StEmit : wpps_pkg::StIdle;
      end
      wpps_pkg::StEmit: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.step = 1'b1;
          if (sts_i.last) begin
            state_d = wpps_pkg::StIdle;
          end
        end
      end
      default: state_d = wpps_pkg::StIdle;
    endcase
  end

  `ASSERT_ALWAYS(a_eval_after_load, cmd_o.load |=> state_q == wpps_pkg::StEval, "no eval after load")
  `ASSERT_ALWAYS(a_quiet_item, (state_q == wpps_pkg::StEval && !sts_i.emit_any) |=> state_q == wpps_pkg::StIdle, "item without results did not return to idle")
  `ASSERT_ALWAYS(a_last_ends_burst, (cmd_o.step && sts_i.last) |=> state_q == wpps_pkg::StIdle, "burst continued past its last transfer")

endmodule

`default_nettype wire

FILE: design/wpps_dp.sv
// ----------------------------------------------------------------------------
// wpps_dp
// Datapath: window, sequence and ack state, burst sizing and result fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wpps_dp #(
  parameter int unsigned MAX_WINDOW = wpps_pkg::MaxWindowDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wpps_pkg::cfg_t   cfg_i,
  input  wpps_pkg::in_t    in_data_i,
  input  wpps_pkg::cmd_t   cmd_i,
  output wpps_pkg::sts_t   sts_o,
  output wpps_pkg::out_t   out_data_o
);

  localparam int unsigned WinW  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned WinRst =
    (int'(wpps_pkg::InitialWindowRst) > MAX_WINDOW) ? MAX_WINDOW
                                                    : int'(wpps_pkg::InitialWindowRst);
  localparam int unsigned DiffW = wpps_pkg::IdW + 1;

  wpps_pkg::in_t                          item_q;
  logic [WinW-1:0]                        window_q, window_d;
  logic [wpps_pkg::SeqW-1:0]              sent_q, sent_d;
  logic signed [wpps_pkg::IdW-1:0]        hack_q, hack_d;
  logic signed [wpps_pkg::IdW-1:0]        roam_q, roam_d;
  logic [wpps_pkg::AddrW-1:0]             peer_q, peer_d;
  logic                                   known_q, known_d;
  logic [wpps_pkg::DeadlineW-1:0]         nst_q, nst_d;
  logic [WinW-1:0]                        rem_q, rem_d;

  logic [wpps_pkg::CfgWinW-1:0]           win_ext, win_inc, win_new;
  logic                                   is_ack, do_roam, from_own;
  logic [DiffW-1:0]                       diff;
  logic [wpps_pkg::IdW-1:0]               outstanding;
  logic                                   burst, extra, peer_ok, tick_send;
  logic [WinW-1:0]                        amount;
  logic [wpps_pkg::DeadlineW-1:0]         now_ext;

  // Window steering for an ack from the own id: grow by one toward the
  // target, or shrink by the fixed step when above it.
  always_comb begin
    win_ext = wpps_pkg::CfgWinW'(window_q);
    if (win_ext < cfg_i.target_window && window_q < WinW'(MAX_WINDOW)) begin
      win_inc = win_ext + 1'b1;
    end else begin
      win_inc = win_ext;
    end
    if (win_inc > cfg_i.target_window) begin
      win_new = (win_inc > wpps_pkg::CfgWinW'(wpps_pkg::ShrinkStep))
              ? win_inc - wpps_pkg::CfgWinW'(wpps_pkg::ShrinkStep) : '0;
    end else begin
      win_new = win_inc;
    end
  end

  assign is_ack   = item_q.rx_sequence == wpps_pkg::MinusOne;
  assign do_roam  = cfg_i.server_mode && (item_q.rx_sender > roam_q)
                 && (item_q.rx_ack == wpps_pkg::MinusOne);
  assign from_own = item_q.rx_sender == cfg_i.own_id;

  // Packets in flight, floored at zero. A negative difference also covers a
  // wrapped sequence counter.
  assign diff        = {2'b00, sent_q} - {hack_q[wpps_pkg::IdW-1], hack_q} - DiffW'(1);
  assign outstanding = diff[DiffW-1] ? '0 : diff[wpps_pkg::IdW-1:0];
  assign burst       = outstanding < wpps_pkg::IdW'(window_q);
  assign amount      = window_q - WinW'(outstanding);
  assign now_ext     = {1'b0, item_q.now_ns};
  assign extra       = !burst && (nst_q < now_ext);
  assign peer_ok     = cfg_i.server_mode ? known_q : 1'b1;
  assign tick_send   = (item_q.op == wpps_pkg::OpTick) && peer_ok && (burst || extra);

  always_comb begin
    window_d = window_q;
    sent_d   = sent_q;
    hack_d   = hack_q;
    roam_d   = roam_q;
    peer_d   = peer_q;
    known_d  = known_q;
    nst_d    = nst_q;
    rem_d    = rem_q;
    if (cmd_i.eval) begin
      if (item_q.op == wpps_pkg::OpRx && is_ack) begin
        if (do_roam) begin
          roam_d  = item_q.rx_sender;
          peer_d  = item_q.rx_source;
          known_d = 1'b1;
        end
        if (from_own) begin
          if (item_q.rx_ack > hack_q) begin
            hack_d = item_q.rx_ack;
          end
          window_d = WinW'(win_new);
        end
      end
      if (tick_send) begin
        rem_d = burst ? amount : WinW'(1);
        nst_d = now_ext + wpps_pkg::DeadlineW'(cfg_i.send_interval);
      end
    end
    if (cmd_i.step) begin
      sent_d = sent_q + 1'b1;
      rem_d  = rem_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WinW'(WinRst);
      sent_q   <= '0;
      hack_q   <= wpps_pkg::MinusOne;
      roam_q   <= wpps_pkg::MinusOne;
      peer_q   <= '0;
      known_q  <= 1'b0;
      nst_q    <= '0;
      rem_q    <= '0;
    end else begin
      window_q <= window_d;
      sent_q   <= sent_d;
      hack_q   <= hack_d;
      roam_q   <= roam_d;
      peer_q   <= peer_d;
      known_q  <= known_d;
      nst_q    <= nst_d;
      rem_q    <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
  end

  assign sts_o.emit_any = tick_send;
  assign sts_o.last     = rem_q == WinW'(1);

  assign out_data_o.tx_sequence = sent_q;
  assign out_data_o.tx_dest     = cfg_i.server_mode ? peer_q : cfg_i.preset_peer;
  assign out_data_o.tx_time     = item_q.now_ns;
  assign out_data_o.tx_last     = sts_o.last;

  `ASSERT_NEVER(a_window_cap, window_q > WinW'(MAX_WINDOW), "window above its cap")
  `ASSERT_NEVER(a_step_with_work, cmd_i.step && rem_q == '0, "transfer with no packet left")
  `ASSERT_ALWAYS(a_seq_advance, cmd_i.step |=> sent_q == $past(sent_q) + 1'b1, "sequence did not advance on transfer")

endmodule

`default_nettype wire

FILE: design/window_paced_packet_sender.sv
// A tick's first packet is offered once the controller has gone from idle through
// its eval state to the emit state; a received packet passes only through idle and eval.
// A burst leaves one transfer per cycle while the output does not stall. The next
// item is accepted in the cycle after the last transfer of the burst. Reset (rst_ni,
// asynchronous, active low) restores config, control and flow registers at once,
// but not the held item; no clearing pass is needed.
// ----------------------------------------------------------------------------
// window_paced_packet_sender
// Window-limited packet sender with ack-driven window steering and interval timer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module window_paced_packet_sender #(
  parameter int unsigned MAX_WINDOW = wpps_pkg::MaxWindowDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [wpps_pkg::ApbAddrW-1:0]      paddr,
  input  wire logic [wpps_pkg::ApbDataW-1:0]      pwdata,
  output logic [wpps_pkg::ApbDataW-1:0]           prdata,
  output logic                                    pready,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wpps_pkg::in_t                           in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output wpps_pkg::out_t                          out_data_o
);

  wpps_pkg::cfg_t cfg;
  wpps_pkg::cmd_t cmd;
  wpps_pkg::sts_t sts;

  wpps_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wpps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wpps_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

FILE: tb/sv/window_paced_packet_sender_tb.sv
// ----------------------------------------------------------------------------
// window_paced_packet_sender_tb
// Drives received packets and ticks into the sender, predicts every transmitted
// packet from a shadow copy of the flow state and compares each transfer on the
// output channel field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module window_paced_packet_sender_tb;
  import wpps_pkg::*;

  localparam int MaxWin        = MaxWindowDef;
  localparam int SettleCycles  = 8;
  localparam int TailCycles    = 16;
  localparam int WatchdogLimit = 4000;
  localparam int NumPhases     = 8;
  localparam int PhaseItems    = 31;
  localparam logic [RegIdxW-1:0] UnmappedIdxLo = 3'd6;
  localparam logic [RegIdxW-1:0] UnmappedIdxHi = 3'd7;
  localparam logic [IdW-1:0]     IdMax         = 32'h7fff_ffff;
  localparam logic [TimeW-1:0]   TimeMax       = '1;

  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [ApbAddrW-1:0] paddr    = '0;
  logic [ApbDataW-1:0] pwdata   = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_t                 in_data  = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_t                out_data;

  // Shadow of the registers and of the flow state.
  cfg_t                 shadow_cfg;
  int                   win_size;
  int                   acked_max;
  int                   roam_max;
  logic [SeqW-1:0]      seq_next;
  logic [AddrW-1:0]     peer_addr;
  logic                 peer_seen;
  logic [DeadlineW-1:0] deadline;

  out_t expected_pkts[$];
  int   error_count   = 0;
  int   in_idle_pct   = 0;
  int   out_stall_pct = 0;

  window_paced_packet_sender dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall <= (out_stall_pct != 0) && ($urandom_range(99) < out_stall_pct);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_t make_tick(input logic [TimeW-1:0] now);
    in_t item;
    item = '0;
    item.op = OpTick;
    item.rx_sequence = $urandom;
    item.rx_ack = $urandom;
    item.rx_sender = $urandom;
    item.rx_source = rand64();
    item.now_ns = now;
    return item;
  endfunction

  function automatic in_t make_rx(input int seq, input int ack, input int sender,
                                  input logic [AddrW-1:0] source);
    in_t item;
    item = '0;
    item.op = OpRx;
    item.rx_sequence = seq;
    item.rx_ack = ack;
    item.rx_sender = sender;
    item.rx_source = source;
    item.now_ns = rand64();
    return item;
  endfunction

  // Updates the shadow state for one accepted item and queues the packets it sends.
  function automatic void predict_packets(input in_t item);
    out_t                 pkt;
    longint               pending;
    int                   room;
    int                   total;
    logic [DeadlineW-1:0] now64;
    if (item.op == OpRx) begin
      if ($signed(item.rx_sequence) != -1) return;
      if (shadow_cfg.server_mode && $signed(item.rx_sender) > roam_max &&
          $signed(item.rx_ack) == -1) begin
        roam_max = $signed(item.rx_sender);
        peer_addr = item.rx_source;
        peer_seen = 1'b1;
      end
      if ($signed(item.rx_sender) != $signed(shadow_cfg.own_id)) return;
      if ($signed(item.rx_ack) > acked_max) acked_max = $signed(item.rx_ack);
      if (win_size < int'(shadow_cfg.target_window) && win_size < MaxWin) win_size++;
      if (win_size > int'(shadow_cfg.target_window)) begin
        win_size = (win_size > ShrinkStep) ? win_size - ShrinkStep : 0;
      end
      return;
    end
    if (shadow_cfg.server_mode && !peer_seen) return;
    now64 = {1'b0, item.now_ns};
    pending = longint'(seq_next) - longint'(acked_max) - 1;
    if (pending < 0) pending = 0;
    room = (pending < win_size) ? int'(win_size - pending) : 0;
    total = room;
    if (room != 0) deadline = now64 + DeadlineW'(shadow_cfg.send_interval);
    // The interval timer adds one packet only when the window gave none.
    if (deadline < now64) begin
      total++;
      deadline = now64 + DeadlineW'(shadow_cfg.send_interval);
    end
    pkt.tx_dest = shadow_cfg.server_mode ? peer_addr : shadow_cfg.preset_peer;
    pkt.tx_time = item.now_ns;
    for (int k = 0; k < total; k++) begin
      pkt.tx_sequence = seq_next;
      pkt.tx_last = (k == total - 1);
      expected_pkts.push_back(pkt);
      seq_next++;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  always @(negedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_pkts.size() == 0) begin
        report_mismatch("unexpected packet, tx_sequence", out_data.tx_sequence, '0);
      end else begin
        want = expected_pkts.pop_front();
        if (out_data.tx_sequence !== want.tx_sequence)
          report_mismatch("tx_sequence", out_data.tx_sequence, want.tx_sequence);
        if (out_data.tx_dest !== want.tx_dest)
          report_mismatch("tx_dest", out_data.tx_dest, want.tx_dest);
        if (out_data.tx_time !== want.tx_time)
          report_mismatch("tx_time", out_data.tx_time, want.tx_time);
        if (out_data.tx_last !== want.tx_last)
          report_mismatch("tx_last", out_data.tx_last, want.tx_last);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(negedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Called at a rising edge; returns at the rising edge of the transfer.
  task automatic send_item(input in_t item);
    if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(negedge clk_i);
    while (in_stall) begin
      @(posedge clk_i);
      @(negedge clk_i);
    end
    predict_packets(item);
    @(posedge clk_i);
  endtask

  // Waits until every expected packet has left and the block has gone idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_pkts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [ApbDataW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ApbAddrW'(idx) << RegIdxLsb;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegTarget:   shadow_cfg.target_window = value[CfgWinW-1:0];
      RegInitial:  shadow_cfg.initial_window = value[CfgWinW-1:0];
      RegOwnId:    shadow_cfg.own_id = value[IdW-1:0];
      RegInterval: shadow_cfg.send_interval = value[IntervalW-1:0];
      RegServer:   shadow_cfg.server_mode = value[0];
      RegPreset:   shadow_cfg.preset_peer = value[AddrW-1:0];
      default: ;
    endcase
  endtask

  // Reset values: a full first burst, then a quiet tick, then one timer packet.
  task automatic test_reset_defaults();
    settle();
    send_item(make_tick(63'd0));
    send_item(make_tick(63'd1000000));
    send_item(make_tick(63'd1000001));
    settle();
  endtask

  // Non-acks and foreign acks are ignored; own acks raise the window.
  task automatic test_ack_window();
    settle();
    send_item(make_rx(7, 5, 0, rand64()));
    send_item(make_rx(-1, 10, 9, rand64()));
    send_item(make_rx(-1, 10, 0, rand64()));
    send_item(make_rx(-1, 3, 0, rand64()));
    send_item(make_tick(63'd2000000));
    // An ack ahead of the sent count drives the in-flight difference below zero.
    send_item(make_rx(-1, 30, 0, rand64()));
    send_item(make_tick(63'd2000005));
    settle();
  endtask

  task automatic test_register_extremes();
    settle();
    write_reg(RegPreset, '1);
    write_reg(RegOwnId, 64'hffff_ffff);
    write_reg(RegTarget, '0);
    write_reg(RegInterval, '0);
    write_reg(RegInitial, 64'd63);
    write_reg(UnmappedIdxLo, '1);
    write_reg(UnmappedIdxHi, '1);
    // With a zero target the window collapses, leaving only the timer packet.
    send_item(make_rx(-1, 40, -1, rand64()));
    send_item(make_tick(TimeMax));
    send_item(make_tick(TimeMax));
    settle();
    write_reg(RegTarget, 64'd63);
    write_reg(RegInterval, 64'hffff_ffff);
    send_item(make_rx(-1, -1, -1, rand64()));
    send_item(make_tick(63'd5));
    settle();
  endtask

  task automatic test_server_roam();
    settle();
    write_reg(RegServer, 64'd1);
    send_item(make_tick(63'd10));
    send_item(make_rx(-1, -1, -1, 48'h0000_0000_00a1));
    send_item(make_rx(-1, 0, 5, 48'h0000_0000_00b2));
    send_item(make_tick(63'd12));
    send_item(make_rx(-1, -1, 5, 48'h5555_aaaa_00c3));
    send_item(make_tick(63'd20));
    send_item(make_rx(-1, -1, 3, 48'h0000_0000_00d4));
    send_item(make_rx(-1, -1, int'(IdMax), 48'haaaa_5555_ffe5));
    send_item(make_tick(63'd30));
    settle();
  endtask

  // Mostly well-formed traffic: ticks, acks trailing the sent count, roaming
  // senders, and a share of dropped or foreign packets.
  task automatic test_random_phase(input int phase);
    logic [TimeW-1:0] wall;
    longint           ack_val;
    int               pick;
    int               sender;
    int               ack;
    settle();
    case (phase % 4)
      0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1: begin in_idle_pct = 81; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 81; end
      default: begin in_idle_pct = 21; out_stall_pct = 21; end
    endcase
    write_reg(RegTarget, (phase == 0) ? 64'd63 : (phase == 1) ? 64'd1 :
                         64'($urandom_range(1, 63)));
    write_reg(RegInitial, 64'($urandom_range(0, 63)));
    write_reg(RegOwnId, (phase == 2) ? 64'(IdMax) : (phase == 5) ? 64'hffff_ffff :
                        64'($urandom_range(0, 3)));
    write_reg(RegInterval, (phase == 1) ? 64'd0 : (phase == 4) ? 64'hffff_ffff :
                           (phase % 2 == 1) ? 64'd1000000 : 64'($urandom_range(0, 20000)));
    write_reg(RegServer, 64'(phase % 3 == 2));
    write_reg(RegPreset, rand64());
    wall = 63'($urandom);
    repeat (PhaseItems) begin
      wall = wall + 63'($urandom_range(0, 3)) * 63'(shadow_cfg.send_interval >> 1) +
             63'($urandom_range(0, 9));
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_item(make_tick(($urandom_range(99) < 3) ? 63'(rand64()) : wall));
      end else if (pick < 78) begin
        ack_val = longint'(seq_next) - 1 - longint'($urandom_range(0, 6));
        if ($urandom_range(99) < 5) ack_val = longint'(seq_next) + $urandom_range(1, 8);
        if (ack_val < -1) ack_val = -1;
        sender = ($urandom_range(9) == 0) ? int'($urandom_range(0, 7)) :
                 int'($signed(shadow_cfg.own_id));
        send_item(make_rx(-1, int'(ack_val), sender, rand64()));
      end else if (pick < 88) begin
        sender = (roam_max < int'(IdMax) - 8) ? roam_max + int'($urandom_range(1, 4)) :
                 int'($urandom_range(0, IdMax));
        ack = ($urandom_range(99) < 85) ? -1 : int'($urandom_range(0, IdMax));
        send_item(make_rx(-1, ack, sender, rand64()));
      end else begin
        send_item(make_rx(int'($urandom_range(0, IdMax)), int'($urandom_range(0, IdMax)),
                          int'($urandom_range(0, IdMax)), rand64()));
      end
    end
    settle();
  endtask

  initial begin
    shadow_cfg.target_window = TargetWindowRst;
    shadow_cfg.initial_window = InitialWindowRst;
    shadow_cfg.own_id = '0;
    shadow_cfg.send_interval = SendIntervalRst;
    shadow_cfg.server_mode = 1'b0;
    shadow_cfg.preset_peer = '0;
    win_size = (int'(InitialWindowRst) > MaxWin) ? MaxWin : int'(InitialWindowRst);
    acked_max = -1;
    roam_max = -1;
    seq_next = '0;
    peer_addr = '0;
    peer_seen = 1'b0;
    deadline = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_ack_window();
    test_register_extremes();
    test_server_roam();
    for (int p = 0; p < NumPhases; p++) test_random_phase(p);
    settle();
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0 && expected_pkts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
